### rtl/core/assert_macros.svh
// assertion shorthands for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/irk_pkg.sv
package irk_pkg;

   // internal values live in [-2^31, 2^31-1] and are held in one bit more than Q16.16
   localparam int VAL_W  = 33;
   localparam int DATA_W = 32;
   localparam int CFG_W  = 31;
   localparam int DT_W   = 16;
   localparam int STEP_W = 6;
   localparam int PROD_W = 64;
   localparam int MAG_W  = 48;

   localparam logic [STEP_W-1:0] LAST_STEP = 6'd46;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 33'sd2147483647;
   localparam logic signed [VAL_W-1:0] VAL_MIN = -33'sd2147483648;
   localparam logic signed [VAL_W:0]   SUM_MAX = 34'sd2147483647;
   localparam logic signed [VAL_W:0]   SUM_MIN = -34'sd2147483648;

   localparam logic [MAG_W-1:0]  MAG_POS_LIMIT = 48'h0000_7FFF_FFFF;
   localparam logic [MAG_W-1:0]  MAG_NEG_LIMIT = 48'h0000_8000_0000;
   localparam logic [PROD_W-1:0] ROUND_HALF    = 64'h0000_0000_0000_8000;
   localparam int                FRAC_BITS     = 16;

   // floor(n / 6) = (n * RECIP_SIX) >> DIV6_SHIFT for any 32-bit n
   localparam logic [31:0] RECIP_SIX  = 32'hAAAA_AAAB;
   localparam int          DIV6_SHIFT = 34;
   localparam logic [31:0] DIV6_BIAS  = 32'd3;

   localparam logic [CFG_W-1:0] KM_RESET = 31'd573440;
   localparam logic [CFG_W-1:0] QM_RESET = 31'd32768;
   localparam logic [CFG_W-1:0] IM_RESET = 31'd81920;

   typedef enum logic [1:0] {
      CSR_STIFFNESS   = 2'd0,
      CSR_DAMPING     = 2'd1,
      CSR_INV_INERTIA = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_SMUL,
      MODE_DIV6
   } mul_mode_type;

   typedef struct packed {
      logic         start;
      mul_mode_type mode;
      logic         negate;
   } mul_cmd_type;

   typedef enum logic [1:0] {
      UOP_ADD,
      UOP_MUL,
      UOP_MULNEG,
      UOP_DIV6
   } uop_kind_type;

   typedef enum logic [4:0] {
      SRC_ZERO,
      SRC_P,
      SRC_V,
      SRC_TP,
      SRC_TV,
      SRC_KV,
      SRC_SP,
      SRC_SV,
      SRC_T,
      SRC_FM,
      SRC_KM,
      SRC_QM,
      SRC_IM,
      SRC_DT,
      SRC_HDT,
      SRC_FORCE,
      SRC_REF
   } src_type;

   typedef enum logic [3:0] {
      DST_P,
      DST_V,
      DST_TP,
      DST_TV,
      DST_KV,
      DST_SP,
      DST_SV,
      DST_T,
      DST_FM,
      DST_OUT
   } dst_type;

   typedef struct packed {
      uop_kind_type kind;
      src_type      src_a;
      src_type      src_b;
      dst_type      dst;
   } uop_type;

   function automatic uop_type make_uop(uop_kind_type kind, src_type a, src_type b,
                                        dst_type d);
      uop_type u;
      u.kind  = kind;
      u.src_a = a;
      u.src_b = b;
      u.dst   = d;
      return u;
   endfunction

   // one rk4 step; the k for position is always the trial velocity tv
   function automatic uop_type uop_at(logic [STEP_W-1:0] step);
      uop_type u;
      case (step)
         6'd0:  u = make_uop(UOP_MUL,    SRC_IM,  SRC_FORCE, DST_FM);
         // k1
         6'd1:  u = make_uop(UOP_MULNEG, SRC_KM,  SRC_TP,   DST_T);
         6'd2:  u = make_uop(UOP_MULNEG, SRC_QM,  SRC_TV,   DST_KV);
         6'd3:  u = make_uop(UOP_ADD,    SRC_T,   SRC_KV,   DST_KV);
         6'd4:  u = make_uop(UOP_ADD,    SRC_KV,  SRC_FM,   DST_KV);
         6'd5:  u = make_uop(UOP_ADD,    SRC_KV,  SRC_ZERO, DST_SV);
         6'd6:  u = make_uop(UOP_MUL,    SRC_HDT, SRC_TV,   DST_T);
         6'd7:  u = make_uop(UOP_ADD,    SRC_P,   SRC_T,    DST_TP);
         6'd8:  u = make_uop(UOP_MUL,    SRC_HDT, SRC_KV,   DST_T);
         6'd9:  u = make_uop(UOP_ADD,    SRC_V,   SRC_T,    DST_TV);
         // k2
         6'd10: u = make_uop(UOP_MULNEG, SRC_KM,  SRC_TP,   DST_T);
         6'd11: u = make_uop(UOP_MULNEG, SRC_QM,  SRC_TV,   DST_KV);
         6'd12: u = make_uop(UOP_ADD,    SRC_T,   SRC_KV,   DST_KV);
         6'd13: u = make_uop(UOP_ADD,    SRC_KV,  SRC_FM,   DST_KV);
         6'd14: u = make_uop(UOP_ADD,    SRC_TV,  SRC_TV,   DST_T);
         6'd15: u = make_uop(UOP_ADD,    SRC_SP,  SRC_T,    DST_SP);
         6'd16: u = make_uop(UOP_ADD,    SRC_KV,  SRC_KV,   DST_T);
         6'd17: u = make_uop(UOP_ADD,    SRC_SV,  SRC_T,    DST_SV);
         6'd18: u = make_uop(UOP_MUL,    SRC_HDT, SRC_TV,   DST_T);
         6'd19: u = make_uop(UOP_ADD,    SRC_P,   SRC_T,    DST_TP);
         6'd20: u = make_uop(UOP_MUL,    SRC_HDT, SRC_KV,   DST_T);
         6'd21: u = make_uop(UOP_ADD,    SRC_V,   SRC_T,    DST_TV);
         // k3
         6'd22: u = make_uop(UOP_MULNEG, SRC_KM,  SRC_TP,   DST_T);
         6'd23: u = make_uop(UOP_MULNEG, SRC_QM,  SRC_TV,   DST_KV);
         6'd24: u = make_uop(UOP_ADD,    SRC_T,   SRC_KV,   DST_KV);
         6'd25: u = make_uop(UOP_ADD,    SRC_KV,  SRC_FM,   DST_KV);
         6'd26: u = make_uop(UOP_ADD,    SRC_TV,  SRC_TV,   DST_T);
         6'd27: u = make_uop(UOP_ADD,    SRC_SP,  SRC_T,    DST_SP);
         6'd28: u = make_uop(UOP_ADD,    SRC_KV,  SRC_KV,   DST_T);
         6'd29: u = make_uop(UOP_ADD,    SRC_SV,  SRC_T,    DST_SV);
         6'd30: u = make_uop(UOP_MUL,    SRC_DT,  SRC_TV,   DST_T);
         6'd31: u = make_uop(UOP_ADD,    SRC_P,   SRC_T,    DST_TP);
         6'd32: u = make_uop(UOP_MUL,    SRC_DT,  SRC_KV,   DST_T);
         6'd33: u = make_uop(UOP_ADD,    SRC_V,   SRC_T,    DST_TV);
         // k4
         6'd34: u = make_uop(UOP_MULNEG, SRC_KM,  SRC_TP,   DST_T);
         6'd35: u = make_uop(UOP_MULNEG, SRC_QM,  SRC_TV,   DST_KV);
         6'd36: u = make_uop(UOP_ADD,    SRC_T,   SRC_KV,   DST_KV);
         6'd37: u = make_uop(UOP_ADD,    SRC_KV,  SRC_FM,   DST_KV);
         6'd38: u = make_uop(UOP_ADD,    SRC_SP,  SRC_TV,   DST_SP);
         6'd39: u = make_uop(UOP_ADD,    SRC_SV,  SRC_KV,   DST_SV);
         // state update and result
         6'd40: u = make_uop(UOP_MUL,    SRC_DT,  SRC_SP,   DST_T);
         6'd41: u = make_uop(UOP_DIV6,   SRC_T,   SRC_ZERO, DST_T);
         6'd42: u = make_uop(UOP_ADD,    SRC_P,   SRC_T,    DST_P);
         6'd43: u = make_uop(UOP_MUL,    SRC_DT,  SRC_SV,   DST_T);
         6'd44: u = make_uop(UOP_DIV6,   SRC_T,   SRC_ZERO, DST_T);
         6'd45: u = make_uop(UOP_ADD,    SRC_V,   SRC_T,    DST_V);
         6'd46: u = make_uop(UOP_ADD,    SRC_REF, SRC_P,    DST_OUT);
         default: u = make_uop(UOP_ADD,  SRC_ZERO, SRC_ZERO, DST_T);
      endcase
      return u;
   endfunction

endpackage

### rtl/core/irk_mul.sv
module irk_mul import irk_pkg::*; (
   input  logic                    clock,
   input  mul_cmd_type             cmd,
   input  logic signed [VAL_W-1:0] op_a,
   input  logic signed [VAL_W-1:0] op_b,
   output logic signed [VAL_W-1:0] result
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_ff, neg_in;
   mul_mode_type      mode_ff;
   logic              negate_ff;

   logic [VAL_W-1:0]  abs_a, abs_b;
   logic [31:0]       mag_a, mag_b;
   logic [PROD_W-1:0] rounded;
   logic [MAG_W-1:0]  mag;
   logic signed [VAL_W-1:0] smul_val, quot_val;
   logic [VAL_W-1:0]  mag_ext;

   always_comb begin
      abs_a = op_a[VAL_W-1] ? VAL_W'(-op_a) : op_a;
      abs_b = op_b[VAL_W-1] ? VAL_W'(-op_b) : op_b;
      if (cmd.mode == MODE_DIV6) begin
         // rounded divide: (|x| + 3) / 6 by reciprocal
         mag_a  = abs_a[31:0] + DIV6_BIAS;
         mag_b  = RECIP_SIX;
         neg_in = op_a[VAL_W-1];
      end else begin
         mag_a  = abs_a[31:0];
         mag_b  = abs_b[31:0];
         neg_in = op_a[VAL_W-1] ^ op_b[VAL_W-1];
      end
      prod_in = PROD_W'(mag_a) * PROD_W'(mag_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         prod_ff   <= prod_in;
         neg_ff    <= neg_in;
         mode_ff   <= cmd.mode;
         negate_ff <= cmd.negate;
      end
   end

   always_comb begin
      // round half away from zero on the magnitude, then saturate
      rounded = prod_ff + ROUND_HALF;
      mag     = rounded[PROD_W-1:FRAC_BITS];
      mag_ext = {1'b0, mag[31:0]};
      if (neg_ff) begin
         smul_val = (mag > MAG_NEG_LIMIT) ? VAL_MIN : VAL_W'(-$signed(mag_ext));
      end else begin
         smul_val = (mag > MAG_POS_LIMIT) ? VAL_MAX : $signed(mag_ext);
      end
      quot_val = $signed(VAL_W'(prod_ff[PROD_W-1:DIV6_SHIFT]));
      if (mode_ff == MODE_DIV6) begin
         result = neg_ff ? VAL_W'(-quot_val) : quot_val;
      end else begin
         result = negate_ff ? VAL_W'(-smul_val) : smul_val;
      end
   end

endmodule

### rtl/core/impedance_rk4_integrator.sv
// channel   direction  payload                                          handshake
// req       in         force_delta, time_step, reference_angle          req_valid / req_ready
// rsp       out        joint_angle_command                              rsp_valid / rsp_ready
// csr       in         csr_index (register), csr_data (31-bit value)    csr_valid / csr_ready
//
// each word goes through accept, the micro-op sequence, and handoff to the output register.
// the micro-ops are 19 products on the shared 32x32 multiplier (issue, then write-back) and 28 adds.
// reset (synchronous) clears position and velocity and loads the default coefficients; no clear pass.
// a finished result waits in the output register, so the next word is taken meanwhile;
// a stall on rsp only holds the block once a second result is ready behind it.
module impedance_rk4_integrator import irk_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_force_delta,
   input  logic [DT_W-1:0]          req_time_step,
   input  logic signed [DATA_W-1:0] req_reference_angle,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_joint_angle_command,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic phase_ff, phase_in;
   logic [CFG_W-1:0] km_ff, km_in, qm_ff, qm_in, im_ff, im_in;
   logic signed [DATA_W-1:0] p_ff, p_in, v_ff, v_in;
   logic signed [VAL_W-1:0] tp_ff, tp_in, tv_ff, tv_in, kv_ff, kv_in;
   logic signed [VAL_W-1:0] sp_ff, sp_in, sv_ff, sv_in, t_ff, t_in, fm_ff, fm_in;
   logic signed [DATA_W-1:0] force_ff, force_in, ref_ff, ref_in, res_ff, res_in;
   logic [DT_W-1:0] dt_ff, dt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   uop_type uop;
   mul_cmd_type mul_cmd;
   logic signed [VAL_W-1:0] opa, opb, add_res, mul_res, wr_val;
   logic signed [VAL_W:0] sum;
   logic b_pos, b_neg, wr_en;

   assign uop = uop_at(step_ff);

   function automatic logic signed [VAL_W-1:0] pick(src_type s,
         logic signed [DATA_W-1:0] p, logic signed [DATA_W-1:0] v,
         logic signed [VAL_W-1:0] tp, logic signed [VAL_W-1:0] tv,
         logic signed [VAL_W-1:0] kv, logic signed [VAL_W-1:0] sp,
         logic signed [VAL_W-1:0] sv, logic signed [VAL_W-1:0] t,
         logic signed [VAL_W-1:0] fm, logic [CFG_W-1:0] km, logic [CFG_W-1:0] qm,
         logic [CFG_W-1:0] im, logic [DT_W-1:0] dt, logic signed [DATA_W-1:0] frc,
         logic signed [DATA_W-1:0] rf);
      logic signed [VAL_W-1:0] r;
      case (s)
         SRC_ZERO:  r = '0;
         SRC_P:     r = {p[DATA_W-1], p};
         SRC_V:     r = {v[DATA_W-1], v};
         SRC_TP:    r = tp;
         SRC_TV:    r = tv;
         SRC_KV:    r = kv;
         SRC_SP:    r = sp;
         SRC_SV:    r = sv;
         SRC_T:     r = t;
         SRC_FM:    r = fm;
         SRC_KM:    r = {2'b00, km};
         SRC_QM:    r = {2'b00, qm};
         SRC_IM:    r = {2'b00, im};
         SRC_DT:    r = {{(VAL_W-DT_W){1'b0}}, dt};
         SRC_HDT:   r = {{(VAL_W-DT_W+1){1'b0}}, dt[DT_W-1:1]};
         SRC_FORCE: r = {frc[DATA_W-1], frc};
         SRC_REF:   r = {rf[DATA_W-1], rf};
         default:   r = '0;
      endcase
      return r;
   endfunction

   assign opa = pick(uop.src_a, p_ff, v_ff, tp_ff, tv_ff, kv_ff, sp_ff, sv_ff, t_ff,
                     fm_ff, km_ff, qm_ff, im_ff, dt_ff, force_ff, ref_ff);
   assign opb = pick(uop.src_b, p_ff, v_ff, tp_ff, tv_ff, kv_ff, sp_ff, sv_ff, t_ff,
                     fm_ff, km_ff, qm_ff, im_ff, dt_ff, force_ff, ref_ff);

   // saturating add; the clamp depends on the sign of the second operand only
   always_comb begin
      sum   = $signed({opa[VAL_W-1], opa}) + $signed({opb[VAL_W-1], opb});
      b_pos = !opb[VAL_W-1] && (opb != '0);
      b_neg = opb[VAL_W-1];
      if (b_pos && (sum > SUM_MAX)) begin
         add_res = VAL_MAX;
      end else if (b_neg && (sum < SUM_MIN)) begin
         add_res = VAL_MIN;
      end else begin
         add_res = sum[VAL_W-1:0];
      end
   end

   irk_mul u_mul (
      .clock  (clock),
      .cmd    (mul_cmd),
      .op_a   (opa),
      .op_b   (opb),
      .result (mul_res)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      km_in        = km_ff;
      qm_in        = qm_ff;
      im_in        = im_ff;
      p_in         = p_ff;
      v_in         = v_ff;
      tp_in        = tp_ff;
      tv_in        = tv_ff;
      kv_in        = kv_ff;
      sp_in        = sp_ff;
      sv_in        = sv_ff;
      t_in         = t_ff;
      fm_in        = fm_ff;
      force_in     = force_ff;
      ref_in       = ref_ff;
      dt_in        = dt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_cmd.start  = 1'b0;
      mul_cmd.mode   = MODE_SMUL;
      mul_cmd.negate = 1'b0;
      wr_en  = 1'b0;
      wr_val = add_res;

      if (csr_valid) begin
         case (csr_index)
            CSR_STIFFNESS:   km_in = csr_data;
            CSR_DAMPING:     qm_in = csr_data;
            CSR_INV_INERTIA: im_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               force_in = req_force_delta;
               dt_in    = req_time_step;
               ref_in   = req_reference_angle;
               tp_in    = {p_ff[DATA_W-1], p_ff};
               tv_in    = {v_ff[DATA_W-1], v_ff};
               // k1 for position is the current velocity
               sp_in    = {v_ff[DATA_W-1], v_ff};
               step_in  = '0;
               phase_in = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (uop.kind == UOP_ADD) begin
               wr_en  = 1'b1;
               wr_val = add_res;
            end else if (!phase_ff) begin
               mul_cmd.start  = 1'b1;
               mul_cmd.mode   = (uop.kind == UOP_DIV6) ? MODE_DIV6 : MODE_SMUL;
               mul_cmd.negate = (uop.kind == UOP_MULNEG);
               phase_in       = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_val   = mul_res;
               phase_in = 1'b0;
            end
            if (wr_en) begin
               case (uop.dst)
                  DST_P:   p_in   = wr_val[DATA_W-1:0];
                  DST_V:   v_in   = wr_val[DATA_W-1:0];
                  DST_TP:  tp_in  = wr_val;
                  DST_TV:  tv_in  = wr_val;
                  DST_KV:  kv_in  = wr_val;
                  DST_SP:  sp_in  = wr_val;
                  DST_SV:  sv_in  = wr_val;
                  DST_T:   t_in   = wr_val;
                  DST_FM:  fm_in  = wr_val;
                  DST_OUT: res_in = wr_val[DATA_W-1:0];
                  default: ;
               endcase
               if (step_ff == LAST_STEP) begin
                  state_in = ST_DONE;
               end else begin
                  step_in = STEP_W'(step_ff + 1'b1);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         phase_ff     <= 1'b0;
         km_ff        <= KM_RESET;
         qm_ff        <= QM_RESET;
         im_ff        <= IM_RESET;
         p_ff         <= '0;
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         km_ff        <= km_in;
         qm_ff        <= qm_in;
         im_ff        <= im_in;
         p_ff         <= p_in;
         v_ff         <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tp_ff       <= tp_in;
      tv_ff       <= tv_in;
      kv_ff       <= kv_in;
      sp_ff       <= sp_in;
      sv_ff       <= sv_in;
      t_ff        <= t_in;
      fm_ff       <= fm_in;
      force_ff    <= force_in;
      ref_ff      <= ref_in;
      dt_ff       <= dt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready               = (state_ff == ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_joint_angle_command = rsp_data_ff;
   assign csr_ready               = 1'b1;

endmodule

### rtl/core/irk_checker.sv
`include "assert_macros.svh"

module irk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_joint_angle_command
);

   // a taken word keeps the input side busy while it is worked on
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // no result can appear right after a word is taken
   `ASSERT_NEXT(a_no_early_result, clock, reset, req_valid && req_ready, !$rose(rsp_valid))

   // a fresh result always frees the input side
   `ASSERT_IMPLIES(a_result_frees_input, clock, reset, $rose(rsp_valid), req_ready)

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_joint_angle_command))

endmodule

bind impedance_rk4_integrator irk_checker u_irk_checker (.*);
